// ----- design/tksil_pkg.sv -----
// Shared types and constants for the top-k sorted insertion list.
package tksil_pkg;

  localparam int SCORE_W     = 32;
  localparam int TAG_PORT_W  = 16;
  localparam int INDEX_W     = 4;
  localparam int COUNT_OUT_W = 4;

  localparam logic signed [SCORE_W-1:0] NOT_FOUND_SCORE = -32'sd99;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  // Insert chain: what a cell hands to the next one down.
  typedef struct packed {
    logic                      passed;   // a smaller score was seen above
    logic signed [SCORE_W-1:0] score;
    logic [TAG_PORT_W-1:0]     tag;
  } link_t;

  // Read chain: the selected entry ripples toward the last cell.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_PORT_W-1:0]     tag;
  } rd_t;

endpackage

// ----- design/tksil_cell.sv -----
// One list slot: holds an entry, compares on insert, shifts from its upper neighbor.
module tksil_cell
  import tksil_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 4,
  parameter int TW  = 16
) (
  input  logic                      clk,
  input  logic                      ins_en,
  input  logic signed [SCORE_W-1:0] new_score,
  input  logic [TW-1:0]             new_tag,
  input  logic [CW-1:0]             count,
  input  logic [INDEX_W-1:0]        rd_index,
  input  link_t                     link_in,
  input  rd_t                       rd_in,
  output link_t                     link_out,
  output rd_t                       rd_out
);

  logic signed [SCORE_W-1:0] score_r;
  logic [TW-1:0]             tag_r;
  logic                      occupied;
  logic                      lt;
  logic                      at_tail;

  assign occupied = (CW'(IDX) < count);
  assign lt       = occupied && (score_r < new_score);
  assign at_tail  = (CW'(IDX) == count);

  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (link_in.passed) begin
        score_r <= link_in.score;
        tag_r   <= link_in.tag[TW-1:0];
      end else if (lt || at_tail) begin
        score_r <= new_score;
        tag_r   <= new_tag;
      end
    end
  end

  assign link_out.passed = link_in.passed | lt;
  assign link_out.score  = score_r;
  assign link_out.tag    = TAG_PORT_W'(tag_r);

  always_comb begin
    if (32'(rd_index) == 32'(IDX)) begin
      rd_out.score = score_r;
      rd_out.tag   = TAG_PORT_W'(tag_r);
    end else begin
      rd_out = rd_in;
    end
  end

endmodule

// ----- design/top_k_sorted_insert_list.sv -----
// Top level of the top-k sorted insertion list: row of slots plus result register.
// Takes one command per clock (busy stays low) and answers every command with
// exactly one result on the following cycle, flagged by out_valid for one cycle.
// An insert is resolved in that single cycle: every slot compares its score to
// the new one in parallel, and a one-bit chain running down the row of slots
// tells each slot whether to hold, take the new entry or take its upper
// neighbor's entry. A read picks its slot through the same row. The result
// cannot be held off, so it must be taken in the cycle it is shown.
module top_k_sorted_insert_list
  import tksil_pkg::*;
#(
  parameter int CAPACITY = 10,
  parameter int TAG_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic signed [SCORE_W-1:0] in_score,
  input  logic [TAG_PORT_W-1:0]     in_name_tag,
  input  logic [INDEX_W-1:0]        in_index,
  output logic                      out_valid,
  output logic                      out_accepted,
  output logic                      out_found,
  output logic signed [SCORE_W-1:0] out_read_score,
  output logic [TAG_PORT_W-1:0]     out_read_name_tag,
  output logic [COUNT_OUT_W-1:0]    out_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = (TAG_BITS < TAG_PORT_W) ? TAG_BITS : TAG_PORT_W;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic          accepted_r, found_r;
  logic signed [SCORE_W-1:0] read_score_r;
  logic [TAG_PORT_W-1:0]     read_tag_r;
  logic [COUNT_OUT_W-1:0]    count_out_r;

  logic  take;
  logic  ins_en;
  logic  has_room;
  logic  ins_ok;
  logic  found;
  link_t link [CAPACITY+1];
  rd_t   rd   [CAPACITY+1];

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign ins_en   = take && (opcode_t'(in_opcode) == OP_INSERT);
  assign has_room = (count_r < CW'(CAPACITY));

  assign link[0] = '0;
  assign rd[0]   = '0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    tksil_cell #(
      .IDX (g),
      .CW  (CW),
      .TW  (TW)
    ) u_cell (
      .clk       (clk),
      .ins_en    (ins_en),
      .new_score (in_score),
      .new_tag   (in_name_tag[TW-1:0]),
      .count     (count_r),
      .rd_index  (in_index),
      .link_in   (link[g]),
      .rd_in     (rd[g]),
      .link_out  (link[g+1]),
      .rd_out    (rd[g+1])
    );
  end

  // Placed when a smaller score exists or there is room to append.
  assign ins_ok = link[CAPACITY].passed || has_room;
  assign found  = (32'(in_index) < 32'(count_r));

  always_comb begin
    count_nxt = count_r;
    if (ins_en && has_room) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      count_out_r <= COUNT_OUT_W'(count_nxt);
      unique case (opcode_t'(in_opcode))
        OP_INSERT: begin
          accepted_r   <= ins_ok;
          found_r      <= 1'b0;
          read_score_r <= '0;
          read_tag_r   <= '0;
        end
        OP_READ: begin
          accepted_r <= 1'b0;
          found_r    <= found;
          if (found) begin
            read_score_r <= rd[CAPACITY].score;
            read_tag_r   <= rd[CAPACITY].tag;
          end else begin
            read_score_r <= NOT_FOUND_SCORE;
            read_tag_r   <= '0;
          end
        end
        default: begin
          accepted_r   <= 1'b0;
          found_r      <= 1'b0;
          read_score_r <= '0;
          read_tag_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = accepted_r;
  assign out_found         = found_r;
  assign out_read_score    = read_score_r;
  assign out_read_name_tag = read_tag_r;
  assign out_count         = count_out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_en && has_room) |=> count_r == $past(count_r) + CW'(1))
    else $error("count did not grow on append room");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ins_en |=> count_r == $past(count_r))
    else $error("count changed without an insert");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> out_valid)
    else $error("command beat without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> !out_valid)
    else $error("result without command beat");

  a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_accepted && out_found))
    else $error("result marks both placed and found");
`endif

endmodule
